// File: hdl/ppc_pkg.sv
// Package with the item types and fixed constants of the phase corrector.
package ppc_pkg;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLES = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POWER_GAIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_GAIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_APPLY = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANT_ENABLE = 3'd4;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_PHASE = 2'd1;
  localparam logic [1:0] OP_COMMAND = 2'd2;

  localparam logic [1:0] CMD_PRIME = 2'd0;
  localparam logic [1:0] CMD_REARM = 2'd1;
  localparam logic [1:0] CMD_REF_NOW = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic [15:0] REG_MASK = 16'hfff0;
  localparam int unsigned ENABLE_BITS = 12;

  // Antenna count and phase steps per turn; the steps are a power of two.
  localparam int unsigned ANTENNAS = 12;
  localparam int unsigned PHASE_STEPS = 4096;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] antenna;
    logic signed [15:0] sample;
    logic [15:0] phase_register;
    logic [1:0] command;
  } in_item_t;

  typedef struct packed {
    logic [3:0] antenna_out;
    logic write_enable;
    logic [15:0] write_value;
    logic signed [15:0] atmospheric_phase;
    logic average_done;
  } out_item_t;

endpackage

// File: hdl/power_to_phase_corrector_unit.sv
// Top level of the per-antenna power-to-phase correction block.
// A phase check, a command, or a power sample that does not close an average
// passes through the EXEC and OUT states to the result register. A sample that
// closes an average passes instead through a bit-serial divider, which forms the
// average, then a bit-serial multiplier, which scales it by the power gain and
// then the power difference by the phase gain, with a state between the two
// passes for latching the reference. One item is in work at a time; the result
// register holds the finished item, and the next item can be accepted in the
// cycle after that register is taken. Per-antenna state lives in flip-flops.
module power_to_phase_corrector_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ppc_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ppc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [ppc_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ppc_pkg::*;

  localparam int unsigned PSW = $clog2(PHASE_STEPS);
  localparam int unsigned AIW = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV, S_MUL1, S_REF, S_MUL2, S_OUT
  } state_t;

  state_t state;

  logic [5:0] samples_per_average;
  logic signed [15:0] power_gain;
  logic signed [15:0] phase_gain;
  logic apply_enable;
  logic [11:0] antenna_enable;

  logic signed [21:0] sample_sum [ANTENNAS];
  logic [5:0] sample_count [ANTENNAS];
  logic signed [23:0] power_level [ANTENNAS];
  logic signed [23:0] reference_level [ANTENNAS];
  logic signed [15:0] correction_phase [ANTENNAS];
  logic [11:0] delay_phase [ANTENNAS];
  logic [15:0] last_register [ANTENNAS];
  logic reference_armed;

  in_item_t item;
  logic [AIW-1:0] ai;
  logic valid_ant;
  logic enabled;

  logic div_start, div_done;
  logic signed [21:0] div_q;
  logic mul_start, mul_done;
  logic signed [23:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [39:0] mul_p;
  logic signed [23:0] new_power;
  logic signed [23:0] new_ref;

  logic signed [21:0] sum_next;
  logic [5:0] count_next;
  logic [5:0] spa_eff;
  logic [15:0] preg;
  logic [11:0] delay_use;
  logic [PSW-1:0] delay_scaled;
  logic [PSW-1:0] wrapped;
  logic [11:0] back_scaled;
  logic [15:0] nreg;
  logic [15:0] last_use;
  logic write_req;
  logic signed [31:0] ph_floor;
  logic signed [15:0] ph_sat;
  logic signed [23:0] diff;

  ppc_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_next),
    .divisor(count_next), .done(div_done), .quotient(div_q)
  );

  ppc_serial_mult #(.AW(24), .BW(16)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    ai = item.antenna[AIW-1:0];
    valid_ant = 32'(item.antenna) < ANTENNAS;
    enabled = valid_ant && ((32'(item.antenna) >= ENABLE_BITS) ||
              antenna_enable[item.antenna[3:0]]);
    sum_next = sample_sum[ai] + 22'(item.sample);
    count_next = sample_count[ai] + 6'd1;
    spa_eff = (samples_per_average == 6'd0) ? 6'd1 : samples_per_average;
    preg = item.phase_register & REG_MASK;
    delay_use = (preg != last_register[ai]) ? preg[15:4] : delay_phase[ai];
    last_use = (preg != last_register[ai]) ? preg : last_register[ai];
    delay_scaled = PSW'((32'(delay_use) * PHASE_STEPS) >> 12);
    // Mod by a power of two wraps negative sums upward automatically.
    wrapped = delay_scaled + PSW'(correction_phase[ai]);
    back_scaled = 12'((32'(wrapped) << 12) / PHASE_STEPS);
    nreg = {back_scaled, 4'd0};
    write_req = apply_enable && (nreg != last_use);
    // Arithmetic shifts give the floor of the division by 256.
    new_power = 24'(mul_p >>> 8);
    new_ref = (reference_armed || reference_level[ai] == 24'sd0) ?
              power_level[ai] : reference_level[ai];
    diff = power_level[ai] - new_ref;
    ph_floor = 32'(mul_p >>> 8);
    if (mul_p >>> 8 > 40'sd32767) ph_sat = 16'sd32767;
    else if (mul_p >>> 8 < -40'sd32768) ph_sat = -16'sd32768;
    else ph_sat = ph_floor[15:0];
    div_start = (state == S_EXEC) && valid_ant && enabled &&
                item.op == OP_SAMPLE && count_next >= spa_eff;
    mul_start = (state == S_DIV && div_done) || (state == S_REF);
    mul_a = (state == S_DIV) ? 24'(div_q) : diff;
    mul_b = (state == S_DIV) ? power_gain : phase_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      samples_per_average <= 6'd6;
      power_gain <= 16'sd256;
      phase_gain <= 16'sd0;
      apply_enable <= 1'b0;
      antenna_enable <= 12'hfff;
      reference_armed <= 1'b1;
      for (int i = 0; i < ANTENNAS; i++) begin
        sample_sum[i] <= '0;
        sample_count[i] <= '0;
        power_level[i] <= '0;
        reference_level[i] <= '0;
        correction_phase[i] <= '0;
        delay_phase[i] <= '0;
        last_register[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES: samples_per_average <= cfg_data[5:0];
          REG_POWER_GAIN: power_gain <= cfg_data;
          REG_PHASE_GAIN: phase_gain <= cfg_data;
          REG_APPLY: apply_enable <= cfg_data[0];
          REG_ANT_ENABLE: antenna_enable <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_data.antenna_out <= item.antenna;
          out_data.average_done <= 1'b0;
          state <= div_start ? S_DIV : S_OUT;
          if (item.op == OP_PHASE && enabled) begin
            out_data.write_value <= nreg;
            out_data.write_enable <= write_req;
          end else begin
            out_data.write_value <= '0;
            out_data.write_enable <= 1'b0;
          end
          if (item.op == OP_SAMPLE && enabled) begin
            if (!div_start) begin
              sample_sum[ai] <= sum_next;
              sample_count[ai] <= count_next;
            end
          end else if (item.op == OP_PHASE && enabled) begin
            delay_phase[ai] <= delay_use;
            if (preg != last_register[ai]) reference_armed <= 1'b0;
            last_register[ai] <= write_req ? nreg : last_use;
          end else if (item.op == OP_COMMAND) begin
            case (item.command)
              CMD_PRIME: if (valid_ant) last_register[ai] <= preg;
              CMD_REARM, CMD_REF_NOW: begin
                if (item.command == CMD_REARM) reference_armed <= 1'b1;
                for (int i = 0; i < ANTENNAS; i++) begin
                  correction_phase[i] <= '0;
                  reference_level[i] <= power_level[i];
                end
              end
              default: begin
                for (int i = 0; i < ANTENNAS; i++) correction_phase[i] <= '0;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) state <= S_MUL1;
        end
        S_MUL1: begin
          if (mul_done) begin
            power_level[ai] <= new_power;
            sample_sum[ai] <= '0;
            sample_count[ai] <= '0;
            state <= S_REF;
          end
        end
        S_REF: begin
          // The phase multiply starts here on the new power and reference.
          reference_level[ai] <= new_ref;
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_done) begin
            correction_phase[ai] <= ph_sat;
            out_data.average_done <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_OUT)
        out_data.atmospheric_phase <= valid_ant ? correction_phase[ai] : 16'sd0;
    end
  end

  // The multiplier for the phase term must not start before the power is stored.
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1 && mul_done) |=> (state == S_REF))
    else $error("phase multiply out of order");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.average_done) |-> (out_data.write_enable == 1'b0))
    else $error("average result with write request");

endmodule

// File: hdl/ppc_serial_mult.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
module ppc_serial_mult #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  product
);
  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(BW + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] count;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        acc <= '0;
        mcand <= PW'(a);
        mplier <= b;
      end else if (busy) begin
        // The top multiplier bit carries negative weight.
        if (mplier[0]) begin
          if (count == CW'(BW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        count <= count + 1'b1;
        if (count == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

// File: hdl/ppc_serial_div.sv
// Restoring divider for the sample average: one quotient bit per cycle.
module ppc_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [21:0] dividend,
  input  logic [5:0]         divisor,
  output logic               done,
  output logic signed [21:0] quotient
);
  logic [21:0] quo;
  logic [6:0] rem;
  logic neg;
  logic [5:0] dvs;
  logic [4:0] count;
  logic busy;
  logic [6:0] trial;

  always_comb trial = {rem[5:0], quo[21]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        rem <= '0;
        neg <= dividend[21];
        quo <= dividend[21] ? 22'(-dividend) : dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[20:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[20:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == 5'd21) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Truncation toward zero: negate the magnitude quotient.
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// File: bench/ppc_checker.sv
// Checker that predicts and compares every result item of the phase corrector.
`timescale 1ns / 100ps
module ppc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ppc_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ppc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ppc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fails,
  output int                            pending,
  output int                            averages
);
  import ppc_pkg::*;

  localparam int NANT = 12;

  // Configuration copy.
  logic [5:0]         avg_len;
  logic signed [15:0] pwr_gain;
  logic signed [15:0] ph_gain;
  logic               apply_on;
  logic [11:0]        ant_on;

  // Per-antenna state copy.
  int          sum_acc [NANT];
  int          sum_cnt [NANT];
  int          power [NANT];
  int          reference [NANT];
  int          correction [NANT];
  logic [11:0] delay [NANT];
  logic [15:0] last_reg [NANT];
  logic        armed;

  out_item_t expected_results[$];

  function automatic longint floor256(longint v);
    return v >>> 8;
  endfunction

  task automatic correct_item(input in_item_t it, output out_item_t res);
    int a;
    bit in_range, enabled;
    longint p, ph, s;
    logic [15:0] preg, nreg;
    a = it.antenna;
    in_range = a < NANT;
    enabled = in_range && ant_on[a % 12];
    preg = it.phase_register & REG_MASK;
    res = '0;
    res.antenna_out = it.antenna;
    if (in_range && it.op == OP_SAMPLE && enabled) begin
      sum_acc[a] += int'(it.sample);
      sum_cnt[a] = (sum_cnt[a] + 1) & 63;
      if (sum_cnt[a] >= avg_len) begin
        p = floor256(longint'(sum_acc[a] / (sum_cnt[a] != 0 ? sum_cnt[a] : 1)) * pwr_gain);
        power[a] = int'(p);
        sum_acc[a] = 0;
        sum_cnt[a] = 0;
        if (armed || reference[a] == 0) reference[a] = power[a];
        ph = floor256(longint'(ph_gain) * (longint'(power[a]) - reference[a]));
        if (ph > 32767) ph = 32767;
        if (ph < -32768) ph = -32768;
        correction[a] = int'(ph);
        res.average_done = 1'b1;
      end
    end else if (in_range && it.op == OP_PHASE && enabled) begin
      if (preg != last_reg[a]) begin
        delay[a] = preg[15:4];
        armed = 1'b0;
        last_reg[a] = preg;
      end
      s = longint'(delay[a]) + correction[a];
      s = s % 4096;
      if (s < 0) s += 4096;
      nreg = {s[11:0], 4'b0};
      res.write_value = nreg;
      if (apply_on && nreg != last_reg[a]) begin
        last_reg[a] = nreg;
        res.write_enable = 1'b1;
      end
    end else if (it.op == OP_COMMAND) begin
      if (it.command == CMD_PRIME) begin
        if (in_range) last_reg[a] = preg;
      end else begin
        if (it.command == CMD_REARM) armed = 1'b1;
        for (int i = 0; i < NANT; i++) begin
          correction[i] = 0;
          if (it.command != CMD_STOP) reference[i] = power[i];
        end
      end
    end
    if (in_range) res.atmospheric_phase = correction[a][15:0];
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst) begin
      avg_len = 6; pwr_gain = 256; ph_gain = 0; apply_on = 0; ant_on = 12'hfff;
      for (int i = 0; i < NANT; i++) begin
        sum_acc[i] = 0; sum_cnt[i] = 0; power[i] = 0; reference[i] = 0;
        correction[i] = 0; delay[i] = 0; last_reg[i] = 0;
      end
      armed = 1'b1;
      expected_results.delete();
      fails = 0;
      averages = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.antenna_out !== want.antenna_out || got.write_enable !== want.write_enable ||
              got.write_value !== want.write_value ||
              got.atmospheric_phase !== want.atmospheric_phase ||
              got.average_done !== want.average_done) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        correct_item(in_data, want);
        if (want.average_done) averages++;
        expected_results.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES:    avg_len = cfg_data[5:0];
          REG_POWER_GAIN: pwr_gain = cfg_data;
          REG_PHASE_GAIN: ph_gain = cfg_data;
          REG_APPLY:      apply_on = cfg_data[0];
          REG_ANT_ENABLE: ant_on = cfg_data[11:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end
endmodule

// File: bench/tb_power_to_phase_corrector_unit.sv
// Testbench top: stimulus, configuration phases and verdict for the phase corrector.
`timescale 1ns / 100ps
module tb_power_to_phase_corrector_unit;
  import ppc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid;
  logic out_ready = 1'b0;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fails, pending, averages;
  int send_idle, recv_idle;
  int cycles = 0;
  int items_sent;

  power_to_phase_corrector_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ppc_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .averages(averages)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d result items outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= $urandom_range(99) >= recv_idle;

  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic item(input logic [1:0] op, input logic [3:0] ant, input logic [15:0] smp,
                      input logic [15:0] preg, input logic [1:0] cmd);
    in_item_t it;
    it.op = op; it.antenna = ant; it.sample = smp; it.phase_register = preg; it.command = cmd;
    send(it);
  endtask

  // Registers may only change once every result is back and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic configure(input logic [5:0] len, input logic [15:0] pg, input logic [15:0] phg,
                           input logic ap, input logic [11:0] en);
    cfg(REG_SAMPLES, 16'(len));
    cfg(REG_POWER_GAIN, pg);
    cfg(REG_PHASE_GAIN, phg);
    cfg(REG_APPLY, 16'(ap));
    cfg(REG_ANT_ENABLE, 16'(en));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_items(input int count);
    logic [1:0] op;
    logic [3:0] ant;
    logic [15:0] preg;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) op = OP_SAMPLE;
      else if (roll < 85) op = OP_PHASE;
      else if (roll < 96) op = OP_COMMAND;
      else op = 2'd3;
      ant = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
      // A few register values repeat so that unchanged reads are common.
      case ($urandom_range(3))
        0: preg = 16'($urandom);
        1: preg = 16'h0000;
        2: preg = 16'hfff0;
        default: preg = {4'($urandom_range(15)), 12'h100};
      endcase
      item(op, ant, 16'($urandom), preg, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: six samples close an average at full positive scale.
    for (int i = 0; i < 6; i++) item(OP_SAMPLE, 4'd0, 16'h7fff, 16'h0, CMD_PRIME);
    item(OP_PHASE, 4'd0, 16'h0, 16'hfff0, CMD_PRIME);
    settle();

    configure(6'd0, 16'h7fff, 16'h7fff, 1'b1, 12'hffe);
    item(OP_SAMPLE, 4'd1, 16'h8000, 16'h0, CMD_PRIME);
    item(OP_SAMPLE, 4'd1, 16'h7fff, 16'h0, CMD_PRIME);
    item(OP_PHASE, 4'd1, 16'h0, 16'hffff, CMD_PRIME);
    item(OP_PHASE, 4'd1, 16'h0, 16'hffff, CMD_PRIME);
    item(OP_SAMPLE, 4'd0, 16'h1234, 16'h0, CMD_PRIME);
    item(OP_PHASE, 4'd0, 16'h0, 16'h1230, CMD_PRIME);
    item(OP_COMMAND, 4'd0, 16'h0, 16'habcd, CMD_PRIME);
    item(OP_COMMAND, 4'd15, 16'h0, 16'habcd, CMD_PRIME);
    item(OP_COMMAND, 4'd2, 16'h0, 16'h0, CMD_REF_NOW);
    item(OP_SAMPLE, 4'd1, 16'h8000, 16'h0, CMD_PRIME);
    item(OP_PHASE, 4'd1, 16'h0, 16'h0010, CMD_PRIME);
    item(OP_COMMAND, 4'd3, 16'h0, 16'h0, CMD_STOP);
    item(OP_COMMAND, 4'd4, 16'h0, 16'h0, CMD_REARM);
    item(2'd3, 4'd5, 16'hffff, 16'hffff, CMD_STOP);
    item(OP_SAMPLE, 4'd12, 16'h7fff, 16'hffff, CMD_PRIME);
    item(OP_PHASE, 4'd15, 16'h0, 16'hffff, CMD_PRIME);
    settle();

    send_idle = 21; recv_idle = 77;
    configure(6'd2, 16'h8000, 16'h8000, 1'b0, 12'hfff);
    random_items(630);
    settle();

    send_idle = 77; recv_idle = 21;
    configure(6'd63, 16'($urandom), 16'($urandom), 1'b1, 12'($urandom));
    random_items(200);
    settle();
    configure(6'd1, 16'h0100, 16'h0400, 1'b1, 12'h000);
    random_items(100);
    settle();
    configure(6'd3, 16'($urandom), 16'($urandom), 1'b1, 12'hfff);
    random_items(330);
    settle();

    send_idle = 0; recv_idle = 0;
    configure(6'($urandom_range(1, 8)), 16'($urandom), 16'($urandom), 1'b1, 12'($urandom));
    random_items(630);
    settle();

    $display("sent %0d items across seven register settings, %0d averages closed",
             items_sent, averages);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatching result items", fails);
      $display("status: fail");
    end
    $finish;
  end
endmodule
